FILE: rtl/heater_link_protocol_engine_top_macros.svh
// Assertion macros for the boiler link protocol engine.
// Used by the top level; the clock and reset are passed in explicitly.
`ifndef HEATER_LINK_PROTOCOL_ENGINE_TOP_MACROS_SVH
`define HEATER_LINK_PROTOCOL_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HLPE_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");
`define HLPE_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");
`else
`define HLPE_ASSERT_IMPLY(label, clock, resetn, ante, cons)
`define HLPE_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif
`endif

FILE: rtl/hlpe_pkg.sv
// Shared types and constants of the boiler link protocol engine.
// Used by the front, queue, back and top level; depends on nothing.
`default_nettype none
package hlpe_pkg;

    localparam logic [23:0] TIMEOUT_RESET = 24'd60000;
    localparam logic [23:0] TICKS_MAX     = 24'hFFFFFF;
    localparam int QUEUE_DEPTH_DEFAULT    = 4;
    localparam int STEP_W                 = 4;

    localparam logic REG_TIMEOUT = 1'b0;

    localparam logic [7:0] BYTE_WAKE        = 8'h04;
    localparam logic [7:0] BYTE_OFFER       = 8'h05;
    localparam logic [7:0] BYTE_SYNC        = 8'h16;
    localparam logic [7:0] BYTE_ACK         = 8'h06;
    localparam logic [7:0] BYTE_START       = 8'h41;
    localparam logic [7:0] FRAME_LEN_READ   = 8'h05;
    localparam logic [7:0] FRAME_LEN_WRITE  = 8'h06;
    localparam logic [7:0] FUNC_READ        = 8'h01;
    localparam logic [7:0] FUNC_WRITE       = 8'h02;
    localparam logic [7:0] WRITE_COUNT      = 8'h01;
    localparam logic [7:0] DONE_MIN_LEN     = 8'h05;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_WRITE = 2'd3;

    localparam logic [2:0] KIND_TX      = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OFFER,
        PH_NOTINIT,
        PH_READY,
        PH_ANSWER
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TIMEOUT,
        OP_FAIL,
        OP_WAKE,
        OP_PAYLOAD,
        OP_DONE,
        OP_FRAME
    } op_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [7:0] addr_hi;
        logic [7:0] addr_lo;
        logic [7:0] read_length;
        logic [7:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic [7:0] payload_index;
        logic [7:0] reply_addr_hi;
        logic [7:0] reply_addr_lo;
        logic [7:0] reply_length;
        logic       ready_res;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       pre_wake;
        op_t        op;
        logic       ready_flag;
        logic       is_write;
        logic [7:0] data_byte;
        logic [7:0] index;
        logic [7:0] addr_hi;
        logic [7:0] addr_lo;
        logic [7:0] len;
        logic [7:0] sum;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

FILE: rtl/hlpe_front.sv
// Front part of the link engine: accepts items, runs the link state machine
// and classifies each item into a job for the back part. Uses hlpe_pkg.
`default_nettype none
module hlpe_front
    import hlpe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire in_item_t  in_data,
    output logic           in_stall,
    input  wire logic [23:0] timeout,
    input  wire q_status_t q_status,
    output logic           push,
    output job_t           push_job
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  len_field_reg, len_field_next;
    logic [7:0]  exp_hi_reg, exp_hi_next;
    logic [7:0]  exp_lo_reg, exp_lo_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    logic [23:0] elapsed_reg, elapsed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            len_field_reg <= '0;
            exp_hi_reg    <= '0;
            exp_lo_reg    <= '0;
            exp_len_reg   <= '0;
            elapsed_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            len_field_reg <= len_field_next;
            exp_hi_reg    <= exp_hi_next;
            exp_lo_reg    <= exp_lo_next;
            exp_len_reg   <= exp_len_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    logic        accept;
    phase_t      phase_eff;
    logic [23:0] ticks_inc;
    logic        is_write;
    logic [7:0]  f1, f3, f6;
    logic [7:0]  sum;
    logic [8:0]  pay_limit;
    logic [7:0]  b;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign b        = in_data.rx_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        len_field_next = len_field_reg;
        exp_hi_next    = exp_hi_reg;
        exp_lo_next    = exp_lo_reg;
        exp_len_next   = exp_len_reg;
        elapsed_next   = elapsed_reg;
        push_job       = '0;
        push_job.op    = OP_NONE;
        phase_eff      = phase_reg;

        ticks_inc = (elapsed_reg == TICKS_MAX) ? elapsed_reg : elapsed_reg + 24'd1;
        is_write  = (in_data.mode == MODE_WRITE);
        f1        = is_write ? FRAME_LEN_WRITE : FRAME_LEN_READ;
        f3        = is_write ? FUNC_WRITE : FUNC_READ;
        f6        = is_write ? WRITE_COUNT : in_data.read_length;
        sum       = f1 + f3 + in_data.addr_hi + in_data.addr_lo + f6
                    + (is_write ? in_data.write_value : 8'h00);
        pay_limit = {1'b0, len_field_reg} + 9'd3;

        if (accept)
        begin
            if (in_data.mode == MODE_TICK)
            begin
                elapsed_next = ticks_inc;
                if (ticks_inc > timeout)
                begin
                    push_job.op         = OP_TIMEOUT;
                    push_job.ready_flag = (phase_reg == PH_READY);
                    phase_next          = PH_OFFER;
                    elapsed_next        = '0;
                end
                else if (phase_reg == PH_IDLE)
                begin
                    push_job.pre_wake = 1'b1;
                    phase_next        = PH_OFFER;
                    elapsed_next      = '0;
                end
            end
            else
            begin
                if (phase_reg == PH_IDLE)
                begin
                    push_job.pre_wake = 1'b1;
                    phase_eff         = PH_OFFER;
                    phase_next        = PH_OFFER;
                    elapsed_next      = '0;
                end
                if (in_data.mode == MODE_BYTE)
                begin
                    case (phase_eff)
                        PH_OFFER:
                        begin
                            elapsed_next = '0;
                            if (b == BYTE_OFFER)
                            begin
                                phase_next  = PH_NOTINIT;
                                push_job.op = OP_WAKE;
                            end
                            else
                            begin
                                phase_next  = PH_OFFER;
                                push_job.op = OP_FAIL;
                            end
                        end
                        PH_NOTINIT:
                        begin
                            elapsed_next = '0;
                            if (b == BYTE_ACK)
                            begin
                                phase_next = PH_READY;
                            end
                            else
                            begin
                                phase_next  = PH_OFFER;
                                push_job.op = OP_FAIL;
                            end
                        end
                        PH_ANSWER:
                        begin
                            count_next = count_reg + 8'd1;
                            case (count_reg)
                                8'd0:    push_job.op = (b != BYTE_ACK) ? OP_FAIL : OP_NONE;
                                8'd1:    push_job.op = (b != BYTE_START) ? OP_FAIL : OP_NONE;
                                8'd2:    len_field_next = b;
                                8'd3:    push_job.op = OP_NONE;
                                8'd4:    push_job.op = OP_NONE;
                                8'd5:    push_job.op = (b != exp_hi_reg) ? OP_FAIL : OP_NONE;
                                8'd6:    push_job.op = (b != exp_lo_reg) ? OP_FAIL : OP_NONE;
                                8'd7:    push_job.op = (b != exp_len_reg) ? OP_FAIL : OP_NONE;
                                default:
                                begin
                                    if (count_reg != 8'hFF && {1'b0, count_reg} < pay_limit)
                                    begin
                                        push_job.op        = OP_PAYLOAD;
                                        push_job.data_byte = b;
                                        push_job.index     = count_reg - 8'd8;
                                    end
                                    else
                                    begin
                                        count_next = count_reg;
                                        phase_next = PH_READY;
                                        if (len_field_reg > DONE_MIN_LEN)
                                        begin
                                            push_job.op      = OP_DONE;
                                            push_job.addr_hi = exp_hi_reg;
                                            push_job.addr_lo = exp_lo_reg;
                                            push_job.len     = len_field_reg;
                                        end
                                    end
                                end
                            endcase
                            if (push_job.op == OP_FAIL)
                            begin
                                count_next   = count_reg;
                                phase_next   = PH_OFFER;
                                elapsed_next = '0;
                            end
                        end
                        default:
                        begin
                            push_job.op = OP_NONE;
                        end
                    endcase
                end
                else if (phase_eff == PH_READY)
                begin
                    push_job.op        = OP_FRAME;
                    push_job.is_write  = is_write;
                    push_job.data_byte = in_data.write_value;
                    push_job.addr_hi   = in_data.addr_hi;
                    push_job.addr_lo   = in_data.addr_lo;
                    push_job.len       = f6;
                    push_job.sum       = sum;
                    exp_hi_next        = in_data.addr_hi;
                    exp_lo_next        = in_data.addr_lo;
                    exp_len_next       = f6;
                    count_next         = '0;
                    phase_next         = PH_ANSWER;
                    elapsed_next       = '0;
                end
            end
        end
        push = accept && (push_job.pre_wake || push_job.op != OP_NONE);
    end

endmodule
`default_nettype wire

FILE: rtl/hlpe_queue.sv
// Job queue between the front and back parts of the link engine.
// A small register ring with push and pop; uses hlpe_pkg.
`default_nettype none
module hlpe_queue
    import hlpe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head           = slots_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);

endmodule
`default_nettype wire

FILE: rtl/hlpe_back.sv
// Back part of the link engine (uses hlpe_pkg): expands the job at the queue
// head into result transactions, one per cycle unless stalled, into the output register.
`default_nettype none
module hlpe_back
    import hlpe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire job_t      head,
    input  wire q_status_t q_status,
    output logic           pop,
    output logic           out_valid,
    output out_item_t      out_data,
    input  wire logic      out_stall
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [STEP_W-1:0] op_len;
    logic [STEP_W-1:0] total;
    logic [STEP_W-1:0] k;
    logic              load;
    out_item_t         res;

    always_comb
    begin
        case (head.op)
            OP_NONE:    op_len = STEP_W'(0);
            OP_TIMEOUT: op_len = STEP_W'(2);
            OP_FAIL:    op_len = STEP_W'(2);
            OP_WAKE:    op_len = STEP_W'(3);
            OP_PAYLOAD: op_len = STEP_W'(1);
            OP_DONE:    op_len = STEP_W'(1);
            OP_FRAME:   op_len = head.is_write ? STEP_W'(9) : STEP_W'(8);
            default:    op_len = STEP_W'(0);
        endcase
        total = op_len + STEP_W'(head.pre_wake);
        k     = step_reg - STEP_W'(head.pre_wake);

        res      = '0;
        res.kind = KIND_TX;
        if (head.pre_wake && step_reg == '0)
        begin
            res.byte_value = BYTE_WAKE;
        end
        else
        begin
            case (head.op)
                OP_TIMEOUT, OP_FAIL:
                begin
                    if (k == '0)
                    begin
                        res.kind      = (head.op == OP_TIMEOUT) ? KIND_TIMEOUT : KIND_ERROR;
                        res.ready_res = (head.op == OP_TIMEOUT) && head.ready_flag;
                    end
                    else
                    begin
                        res.byte_value = BYTE_WAKE;
                    end
                end
                OP_WAKE:
                begin
                    res.byte_value = (k == '0) ? BYTE_SYNC : 8'h00;
                end
                OP_PAYLOAD:
                begin
                    res.kind          = KIND_PAYLOAD;
                    res.byte_value    = head.data_byte;
                    res.payload_index = head.index;
                end
                OP_DONE:
                begin
                    res.kind          = KIND_DONE;
                    res.reply_addr_hi = head.addr_hi;
                    res.reply_addr_lo = head.addr_lo;
                    res.reply_length  = head.len;
                    res.ready_res     = 1'b1;
                end
                OP_FRAME:
                begin
                    case (k)
                        STEP_W'(0): res.byte_value = BYTE_START;
                        STEP_W'(1): res.byte_value = head.is_write ? FRAME_LEN_WRITE
                                                                   : FRAME_LEN_READ;
                        STEP_W'(2): res.byte_value = 8'h00;
                        STEP_W'(3): res.byte_value = head.is_write ? FUNC_WRITE : FUNC_READ;
                        STEP_W'(4): res.byte_value = head.addr_hi;
                        STEP_W'(5): res.byte_value = head.addr_lo;
                        STEP_W'(6): res.byte_value = head.len;
                        STEP_W'(7): res.byte_value = head.is_write ? head.data_byte
                                                                   : head.sum;
                        default:    res.byte_value = head.sum;
                    endcase
                end
                default:
                begin
                    res.byte_value = BYTE_WAKE;
                end
            endcase
        end
        res.last = (step_reg == total - STEP_W'(1));
    end

    always_comb
    begin
        load           = !q_status.empty && (!out_valid_reg || !out_stall);
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
            if (res.last)
            begin
                step_next = '0;
                pop       = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

FILE: rtl/heater_link_protocol_engine_top.sv
// Top level of the boiler link protocol engine: register port, front, queue and back.
// Depends on hlpe_pkg, hlpe_front, hlpe_queue, hlpe_back and the assertion macros header.
//
// The front part accepts one input transaction per clock cycle as long as the job
// queue (QUEUE_DEPTH entries) has room, and updates the link state at once. Each
// transaction yields zero to nine result transactions, which the back part delivers
// one per cycle while out_stall is low, through a registered output; the sustained
// rate is one result per cycle when the output does not stall.
// The timeout register sits at byte address 0 and should be written only while idle.
`default_nettype none
`include "heater_link_protocol_engine_top_macros.svh"
module heater_link_protocol_engine_top
    import hlpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire in_item_t    in_data,
    output logic             in_stall,
    output logic             out_valid,
    output out_item_t        out_data,
    input  wire logic        out_stall,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [23:0] timeout_reg, timeout_next;
    logic        push;
    job_t        push_job;
    logic        pop;
    job_t        head;
    q_status_t   q_status;

    assign pready = 1'b1;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT)
        begin
            timeout_next = pwdata[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    assign prdata = (paddr[2] == REG_TIMEOUT) ? {8'h00, timeout_reg} : 32'h0;

    hlpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .timeout  (timeout_reg),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    hlpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    hlpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

    `HLPE_ASSERT_IMPLY(a_done_alone_ready, clk, rst_n, out_valid && out_data.kind == KIND_DONE, out_data.ready_res && out_data.last)
    `HLPE_ASSERT_NEXT(a_timeout_then_wake, clk, rst_n, out_valid && !out_stall && out_data.kind == KIND_TIMEOUT, out_valid && out_data.kind == KIND_TX && out_data.byte_value == BYTE_WAKE)
    `HLPE_ASSERT_NEXT(a_queue_drains, clk, rst_n, !q_status.empty && (!out_valid || !out_stall), out_valid)

endmodule
`default_nettype wire
